>>> rtl/mpr_pkg.sv
// Shared types, codes and default sizes of the multi-pipe ring buffer.
`timescale 1ns / 1ps
package mpr_pkg;

	localparam int PIPE_COUNT_DEF = 16;
	localparam int RING_DEPTH_DEF = 4096;

	localparam int CMD_W     = 3;
	localparam int PIPE_ID_W = 4;
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC       = 3'd0,
		CMD_WRITE       = 3'd1,
		CMD_READ        = 3'd2,
		CMD_CLOSE_WRITE = 3'd3,
		CMD_CLOSE_READ  = 3'd4,
		CMD_POLL        = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_EMPTY  = 3'd1,
		STAT_FULL   = 3'd2,
		STAT_EOF    = 3'd3,
		STAT_NOPIPE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		status_t               status;
		logic [BYTE_W-1:0]     read_byte;
		logic [PIPE_ID_W-1:0]  granted_pipe;
		logic                  readable;
		logic                  writable;
		logic                  hangup;
	} rsp_t;

endpackage

>>> rtl/mpr_req_if.sv
// Command channel of the multi-pipe ring buffer.
`timescale 1ns / 1ps
interface mpr_req_if import mpr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [PIPE_ID_W-1:0] pipe_index;
	logic [BYTE_W-1:0]    write_byte;

	modport source (output valid, output command, output pipe_index, output write_byte,
		input ready);
	modport sink (input valid, input command, input pipe_index, input write_byte,
		output ready);
endinterface

>>> rtl/mpr_rsp_if.sv
// Result channel of the multi-pipe ring buffer.
`timescale 1ns / 1ps
interface mpr_rsp_if import mpr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [BYTE_W-1:0]    read_byte;
	logic [PIPE_ID_W-1:0] granted_pipe;
	logic                 readable;
	logic                 writable;
	logic                 hangup;

	modport source (output valid, output status, output read_byte, output granted_pipe,
		output readable, output writable, output hangup, input ready);
	modport sink (input valid, input status, input read_byte, input granted_pipe,
		input readable, input writable, input hangup, output ready);
endinterface

>>> rtl/mpr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module mpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/multi_pipe_ring_buffer.sv
// Top level of the multi-pipe ring buffer: a bank of byte pipes over one shared byte RAM.
// A result passes the pointer RAM lookup, for a read that returns a byte also the byte
// RAM read, then the result register and the output register.
// A new command is taken only in the idle state, once the result of the last one has
// been loaded into the output register; a stalled result output holds off commands.
// Reset: arst_n clears the per-pipe flags and the control state at once; the RAMs are
// not cleared and no sweep runs, so commands are taken from the first cycle after reset.
`timescale 1ns / 1ps
module multi_pipe_ring_buffer import mpr_pkg::*; #(
	parameter int PIPE_COUNT = PIPE_COUNT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mpr_req_if.sink   request,
	mpr_rsp_if.source response
);

	// Widths that follow from the sizes. Only pipes below both PIPE_COUNT and the reach of
	// the 4-bit pipe index are ever handed out.
	localparam int IW   = $clog2(PIPE_COUNT);
	localparam int PW   = $clog2(RING_DEPTH);
	localparam int AW   = $clog2(PIPE_COUNT * RING_DEPTH);
	localparam int LIVE = (PIPE_COUNT < (1 << PIPE_ID_W)) ? PIPE_COUNT : (1 << PIPE_ID_W);

	// Control state and the accepted command.
	state_t              state_q, state_d;
	cmd_t                cmd_s1;
	logic [IW-1:0]       pidx_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                inrange_s1;

	// Per-pipe flags live in flip-flops; they are few and reset must clear them.
	logic [PIPE_COUNT-1:0] busy_q, busy_d;
	logic [PIPE_COUNT-1:0] rdopen_q, rdopen_d;
	logic [PIPE_COUNT-1:0] wrclosed_q, wrclosed_d;

	// Result waiting for the output register, and the output register itself.
	rsp_t res_q, res_d;
	rsp_t out_q;
	logic out_valid_q;
	logic out_load;

	// Pointer RAM: one entry per pipe holding {head, tail}. An entry is always written by
	// an allocate before any command can reach it, so it needs no reset.
	logic             ptr_we;
	logic [IW-1:0]    ptr_waddr;
	logic [2*PW-1:0]  ptr_wdata;
	logic [2*PW-1:0]  ptr_rdata;
	logic [PW-1:0]    head_ptr;
	logic [PW-1:0]    tail_ptr;

	// Byte RAM: pipe p owns the slots p*RING_DEPTH up to p*RING_DEPTH + RING_DEPTH - 1.
	logic              ring_we;
	logic              ring_re;
	logic [AW-1:0]     ring_waddr;
	logic [AW-1:0]     ring_raddr;
	logic [BYTE_W-1:0] ring_rdata;
	logic [AW-1:0]     ring_base;

	logic              accept;
	logic [IW-1:0]     req_pidx;

	assign accept   = request.valid && request.ready;
	assign req_pidx = IW'(request.pipe_index);
	assign request.ready = (state_q == ST_IDLE);

	assign head_ptr  = ptr_rdata[2*PW-1:PW];
	assign tail_ptr  = ptr_rdata[PW-1:0];
	assign ring_base = AW'(pidx_s1) * AW'(RING_DEPTH);

	// Slot after pos, wrapping at the end of the ring.
	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
		return (pos == PW'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
	endfunction

	mpr_ram #(
		.WIDTH(2 * PW),
		.DEPTH(PIPE_COUNT)
	) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (ptr_waddr),
		.wdata (ptr_wdata),
		.re    (accept),
		.raddr (req_pidx),
		.rdata (ptr_rdata)
	);

	mpr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PIPE_COUNT * RING_DEPTH)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (byte_s1),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Capture the command when it is taken; the pointer RAM read is issued in the same cycle.
	// The range check is done one bit wider so that a limit of sixteen pipes stays visible.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(request.command);
			pidx_s1    <= req_pidx;
			byte_s1    <= request.write_byte;
			inrange_s1 <= ({1'b0, request.pipe_index} < (PIPE_ID_W + 1)'(LIVE));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			busy_q     <= '0;
			rdopen_q   <= '0;
			wrclosed_q <= '0;
		end else begin
			state_q    <= state_d;
			busy_q     <= busy_d;
			rdopen_q   <= rdopen_d;
			wrclosed_q <= wrclosed_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state, flag updates and RAM accesses. All work on the addressed pipe happens in
	// the lookup cycle, when its pointers have arrived from the pointer RAM.
	always_comb begin
		logic          live;
		logic          empty;
		logic          alloc_found;
		logic [IW-1:0] alloc_idx;
		logic [PW-1:0] tail_nx;
		logic [PW-1:0] head_nx;

		state_d    = state_q;
		res_d      = res_q;
		busy_d     = busy_q;
		rdopen_d   = rdopen_q;
		wrclosed_d = wrclosed_q;
		ptr_we     = 1'b0;
		ptr_waddr  = pidx_s1;
		ptr_wdata  = {head_ptr, tail_ptr};
		ring_we    = 1'b0;
		ring_re    = 1'b0;
		ring_waddr = ring_base + AW'(tail_ptr);
		ring_raddr = ring_base + AW'(head_ptr);
		out_load   = 1'b0;

		live    = inrange_s1 && busy_q[pidx_s1];
		empty   = (head_ptr == tail_ptr);
		tail_nx = ring_next(tail_ptr);
		head_nx = ring_next(head_ptr);

		// The lowest free pipe wins an allocate.
		alloc_found = 1'b0;
		alloc_idx   = '0;
		for (int i = LIVE - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				alloc_found = 1'b1;
				alloc_idx   = IW'(i);
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				res_d   = '{status: STAT_NOPIPE, default: '0};
				state_d = ST_EMIT;
				case (cmd_s1)
					CMD_ALLOC: begin
						if (alloc_found) begin
							busy_d[alloc_idx]     = 1'b1;
							rdopen_d[alloc_idx]   = 1'b1;
							wrclosed_d[alloc_idx] = 1'b0;
							res_d.status          = STAT_OK;
							res_d.granted_pipe    = PIPE_ID_W'(alloc_idx);
						end
					end
					CMD_WRITE: begin
						if (live && !wrclosed_q[pidx_s1]) begin
							if (tail_nx == head_ptr) begin
								res_d.status = STAT_FULL;
							end else begin
								ring_we      = 1'b1;
								ptr_we       = 1'b1;
								ptr_wdata    = {head_ptr, tail_nx};
								res_d.status = STAT_OK;
							end
						end
					end
					CMD_READ: begin
						if (live && rdopen_q[pidx_s1]) begin
							if (!empty) begin
								ring_re      = 1'b1;
								ptr_we       = 1'b1;
								ptr_wdata    = {head_nx, tail_ptr};
								res_d.status = STAT_OK;
								state_d      = ST_FETCH;
							end else if (wrclosed_q[pidx_s1]) begin
								res_d.status = STAT_EOF;
							end else begin
								res_d.status = STAT_EMPTY;
							end
						end
					end
					CMD_CLOSE_WRITE: begin
						if (live && !wrclosed_q[pidx_s1]) begin
							res_d.status = STAT_OK;
							if (rdopen_q[pidx_s1]) begin
								wrclosed_d[pidx_s1] = 1'b1;
							end else begin
								busy_d[pidx_s1]     = 1'b0;
								wrclosed_d[pidx_s1] = 1'b0;
							end
						end
					end
					CMD_CLOSE_READ: begin
						if (live && rdopen_q[pidx_s1]) begin
							res_d.status      = STAT_OK;
							rdopen_d[pidx_s1] = 1'b0;
							if (wrclosed_q[pidx_s1]) begin
								busy_d[pidx_s1]     = 1'b0;
								wrclosed_d[pidx_s1] = 1'b0;
							end
						end
					end
					CMD_POLL: begin
						if (live) begin
							res_d.status   = STAT_OK;
							res_d.readable = rdopen_q[pidx_s1] &&
								(!empty || wrclosed_q[pidx_s1]);
							res_d.hangup   = rdopen_q[pidx_s1] && empty &&
								wrclosed_q[pidx_s1];
							res_d.writable = !wrclosed_q[pidx_s1] && (tail_nx != head_ptr);
						end
					end
					default: begin
					end
				endcase
				// A fresh allocate resets both pointers of the granted pipe.
				if (cmd_s1 == CMD_ALLOC && alloc_found) begin
					ptr_we = 1'b1;
				end
			end
			ST_FETCH: begin
				res_d.read_byte = ring_rdata;
				state_d         = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || response.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// The pointer RAM is written at the allocated pipe, not the addressed one.
		if (cmd_s1 == CMD_ALLOC && state_q == ST_LOOKUP) begin
			ptr_waddr = alloc_idx;
			ptr_wdata = '0;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.status       = out_q.status;
	assign response.read_byte    = out_q.read_byte;
	assign response.granted_pipe = out_q.granted_pipe;
	assign response.readable     = out_q.readable;
	assign response.writable     = out_q.writable;
	assign response.hangup       = out_q.hangup;

endmodule

>>> bench/mpr_pipe_checker.sv
// Checker of the multi-pipe ring buffer: predicts each result from the accepted commands and compares.
`timescale 1ns / 1ps
module mpr_pipe_checker import mpr_pkg::*; #(
	parameter int PIPES = PIPE_COUNT_DEF,
	parameter int DEPTH = RING_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mpr_req_if   req_ch,
	mpr_rsp_if   rsp_ch,
	output int   errors,
	output int   outstanding
);

	localparam int POS_W       = $clog2(DEPTH);
	localparam int ADDRESSABLE = (PIPES < 16) ? PIPES : 16;
	localparam int PRINT_CAP   = 50;

	logic              pipe_in_use [PIPES];
	logic              reader_live [PIPES];
	logic              writer_shut [PIPES];
	logic [POS_W-1:0]  head_pos    [PIPES];
	logic [POS_W-1:0]  tail_pos    [PIPES];
	logic [BYTE_W-1:0] byte_ram    [PIPES*DEPTH];
	rsp_t              pending_results [$];
	int                fail_cnt = 0;

	task automatic report_mismatch(input string field, input int got, input int want);
		fail_cnt++;
		if (fail_cnt <= PRINT_CAP) begin
			$display("%0t: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
		end
	endtask

	function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos);
		return (pos == POS_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
	endfunction

	function automatic void release_pipe(input int p);
		pipe_in_use[p] = 1'b0;
		reader_live[p] = 1'b0;
		writer_shut[p] = 1'b0;
	endfunction

	// Applies one command to the shadow state and returns the result it must produce.
	task automatic execute_command(input logic [CMD_W-1:0] cmd,
			input logic [PIPE_ID_W-1:0] p, input logic [BYTE_W-1:0] data, output rsp_t r);
		logic live;
		logic empty;
		int   base;
		r = '0;
		r.status = STAT_NOPIPE;
		live = (int'(p) < ADDRESSABLE) && pipe_in_use[p];
		empty = live && (head_pos[p] == tail_pos[p]);
		base = int'(p) * DEPTH;
		case (cmd)
		CMD_ALLOC: begin
			for (int i = 0; i < ADDRESSABLE; i++) begin
				if (!pipe_in_use[i] && r.status != STAT_OK) begin
					pipe_in_use[i] = 1'b1;
					reader_live[i] = 1'b1;
					writer_shut[i] = 1'b0;
					head_pos[i] = '0;
					tail_pos[i] = '0;
					r.granted_pipe = PIPE_ID_W'(i);
					r.status = STAT_OK;
				end
			end
		end
		CMD_WRITE: begin
			if (live && !writer_shut[p]) begin
				if (advance(tail_pos[p]) == head_pos[p]) begin
					r.status = STAT_FULL;
				end else begin
					byte_ram[base + int'(tail_pos[p])] = data;
					tail_pos[p] = advance(tail_pos[p]);
					r.status = STAT_OK;
				end
			end
		end
		CMD_READ: begin
			if (live && reader_live[p]) begin
				if (!empty) begin
					r.read_byte = byte_ram[base + int'(head_pos[p])];
					head_pos[p] = advance(head_pos[p]);
					r.status = STAT_OK;
				end else if (writer_shut[p]) begin
					r.status = STAT_EOF;
				end else begin
					r.status = STAT_EMPTY;
				end
			end
		end
		CMD_CLOSE_WRITE: begin
			if (live && !writer_shut[p]) begin
				writer_shut[p] = 1'b1;
				if (!reader_live[p]) release_pipe(int'(p));
				r.status = STAT_OK;
			end
		end
		CMD_CLOSE_READ: begin
			if (live && reader_live[p]) begin
				reader_live[p] = 1'b0;
				if (writer_shut[p]) release_pipe(int'(p));
				r.status = STAT_OK;
			end
		end
		CMD_POLL: begin
			if (live) begin
				if (reader_live[p]) begin
					r.readable = !empty || writer_shut[p];
					r.hangup = empty && writer_shut[p];
				end
				if (!writer_shut[p]) r.writable = (advance(tail_pos[p]) != head_pos[p]);
				r.status = STAT_OK;
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t fresh;
		if (!arst_n) begin
			for (int i = 0; i < PIPES; i++) begin
				release_pipe(i);
				head_pos[i] = '0;
				tail_pos[i] = '0;
			end
			pending_results.delete();
			outstanding <= 0;
			errors <= fail_cnt;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing outstanding, status", rsp_ch.status, -1);
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch("status", rsp_ch.status, want.status);
					if (rsp_ch.read_byte !== want.read_byte)
						report_mismatch("read_byte", rsp_ch.read_byte, want.read_byte);
					if (rsp_ch.granted_pipe !== want.granted_pipe)
						report_mismatch("granted_pipe", rsp_ch.granted_pipe, want.granted_pipe);
					if (rsp_ch.readable !== want.readable)
						report_mismatch("readable", rsp_ch.readable, want.readable);
					if (rsp_ch.writable !== want.writable)
						report_mismatch("writable", rsp_ch.writable, want.writable);
					if (rsp_ch.hangup !== want.hangup)
						report_mismatch("hangup", rsp_ch.hangup, want.hangup);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				execute_command(req_ch.command, req_ch.pipe_index, req_ch.write_byte, fresh);
				pending_results.push_back(fresh);
			end
			outstanding <= pending_results.size();
			errors <= fail_cnt;
		end
	end

endmodule

>>> bench/multi_pipe_ring_buffer_tb.sv
// Testbench top of the multi-pipe ring buffer: clock, reset, command stimulus, result sink, verdict.
`timescale 1ns / 1ps
module multi_pipe_ring_buffer_tb;
	import mpr_pkg::*;

	localparam int PIPES        = PIPE_COUNT_DEF;
	localparam int DEPTH        = RING_DEPTH_DEF;
	localparam int PERIOD       = 10;
	localparam int RESET_CYCLES = 7;
	// Random session traffic, split around the deep fill of one ring.
	localparam int RANDOM_ITEMS = 850;
	// Bytes written in one run into the fill pipe before it is drained.
	localparam int FILL_BYTES   = 160;
	// The slowest correct run is about twelve hundred and fifty transactions, each at worst
	// both sides at their longest gap plus the block's own handling, plus the one long hold
	// of the sink, so this bound leaves a wide margin.
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int DRAIN_CYCLES = 20;
	// The result sink holds off once for a long stretch so that the block backs up.
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_GAP      = 12;
	localparam logic [PIPE_ID_W-1:0] FILL_PIPE = '0;
	// Command codes outside the defined set; the block must answer them as unused.
	localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_total;
	int   results_owed;
	int   sent_count = 0;
	int   random_items = 0;
	int   cycle_count = 0;
	logic send_calm = 1'b0;
	logic sink_calm = 1'b0;

	mpr_req_if req_ch();
	mpr_rsp_if rsp_ch();

	multi_pipe_ring_buffer #(
		.PIPE_COUNT(PIPES),
		.RING_DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.response(rsp_ch)
	);

	// The checker sees both channels exactly as the block does and keeps its own
	// shadow of the pipes; it hands back only the failure count and how many
	// results are still owed.
	mpr_pipe_checker #(
		.PIPES(PIPES),
		.DEPTH(DEPTH)
	) i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_ch     (req_ch),
		.rsp_ch     (rsp_ch),
		.errors     (mismatch_total),
		.outstanding(results_owed)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic logic [BYTE_W-1:0] random_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Most traffic lands on the low pipes, since allocation always hands out the
	// lowest free one; the rest spreads over the whole index range.
	function automatic logic [PIPE_ID_W-1:0] random_pipe();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7) return PIPE_ID_W'($urandom_range(0, 3));
		if (roll < 9) return PIPE_ID_W'($urandom_range(0, 7));
		return PIPE_ID_W'($urandom_range(0, 15));
	endfunction

	// Offers one command transaction and returns at the edge where it is taken.
	// The idle gap before it is drawn per transaction; in a calm stretch there is
	// none, so valid stays high across back-to-back transactions.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PIPE_ID_W-1:0] pipe,
			input logic [BYTE_W-1:0] data);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.command    <= cmd;
		req_ch.pipe_index <= pipe;
		req_ch.write_byte <= data;
		req_ch.valid      <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent_count++;
		if (sent_count % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
	endtask

	// A short burst of commands that mostly address one pipe, so that writes,
	// reads, polls and closes on the same ring follow each other. About one in
	// ten transactions strays to another pipe, and a few carry undefined codes.
	task automatic run_session();
		logic [PIPE_ID_W-1:0] pipe;
		logic [CMD_W-1:0]     cmd;
		int                   len;
		int                   roll;
		pipe = random_pipe();
		len = $urandom_range(1, 12);
		repeat (len) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) cmd = CMD_ALLOC;
			else if (roll < 43) cmd = CMD_WRITE;
			else if (roll < 73) cmd = CMD_READ;
			else if (roll < 78) cmd = CMD_CLOSE_WRITE;
			else if (roll < 83) cmd = CMD_CLOSE_READ;
			else if (roll < 97) cmd = CMD_POLL;
			else if (roll < 99) cmd = CMD_RSVD_A;
			else cmd = CMD_RSVD_B;
			send_command(cmd, ($urandom_range(0, 9) == 0) ? random_pipe() : pipe, random_byte());
			random_items++;
		end
	endtask

	// Drives one ring deep: a long run of writes, then a drain with a trickle of
	// writes mixed in until reads find the ring empty, and finally end of file and
	// hangup once the write end is closed.
	task automatic fill_and_drain();
		// Closing both ends frees the fill pipe whatever state it is in, so the
		// next allocation is sure to grant it.
		send_command(CMD_CLOSE_WRITE, FILL_PIPE, random_byte());
		send_command(CMD_CLOSE_READ, FILL_PIPE, random_byte());
		send_command(CMD_ALLOC, random_pipe(), random_byte());
		repeat (FILL_BYTES) send_command(CMD_WRITE, FILL_PIPE, random_byte());
		send_command(CMD_POLL, FILL_PIPE, random_byte());
		for (int i = 0; i < FILL_BYTES + 16; i++) begin
			send_command(CMD_READ, FILL_PIPE, random_byte());
			if (i % 32 == 0 && i < FILL_BYTES / 2) begin
				send_command(CMD_WRITE, FILL_PIPE, random_byte());
			end
		end
		send_command(CMD_CLOSE_WRITE, FILL_PIPE, random_byte());
		repeat (8) send_command(CMD_READ, FILL_PIPE, random_byte());
		send_command(CMD_POLL, FILL_PIPE, random_byte());
		send_command(CMD_CLOSE_READ, FILL_PIPE, random_byte());
	endtask

	// Result sink. Each transaction is preceded by a drawn number of cycles with
	// ready low, except in calm stretches. Once, after a few hundred results, it
	// refuses results for a long stretch while commands keep coming, which backs
	// the block up until it stops taking commands.
	initial begin
		int gap;
		int taken;
		taken = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT) gap = HOLD_CYCLES;
			else gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			taken++;
			if (taken % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog: a run that has not finished by the cycle limit has hung.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Command stimulus and verdict.
	initial begin
		req_ch.valid      = 1'b0;
		req_ch.command    = CMD_POLL;
		req_ch.pipe_index = '0;
		req_ch.write_byte = '0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Allocate every pipe and one more, which finds none free;
		// the grants walk through all index bits.
		repeat (17) send_command(CMD_ALLOC, '0, '0);
		// The top pipe gets the byte extremes, then loses its write end: a write after the
		// close is refused, the data still drains, then end of file, a hangup poll, a second
		// close refused, and the read close frees the pipe.
		send_command(CMD_WRITE, 4'hF, 8'hFF);
		send_command(CMD_WRITE, 4'hF, 8'h00);
		send_command(CMD_CLOSE_WRITE, 4'hF, '0);
		send_command(CMD_WRITE, 4'hF, 8'h5A);
		send_command(CMD_READ, 4'hF, '0);
		send_command(CMD_READ, 4'hF, '0);
		send_command(CMD_READ, 4'hF, '0);
		send_command(CMD_POLL, 4'hF, '0);
		send_command(CMD_CLOSE_WRITE, 4'hF, '0);
		send_command(CMD_CLOSE_READ, 4'hF, '0);
		// A freed pipe answers as unused; so do the undefined command codes.
		send_command(CMD_POLL, 4'hF, '0);
		send_command(CMD_RSVD_A, 4'h1, 8'hFF);
		send_command(CMD_RSVD_B, 4'h2, 8'hFF);

		// Random sessions, with the deep fill of one ring in the middle so that
		// later sessions find that pipe in whatever state the fill left it.
		while (random_items < RANDOM_ITEMS / 2) run_session();
		fill_and_drain();
		while (random_items < RANDOM_ITEMS) run_session();

		// Let every owed result arrive, then allow for any stray extra one.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_total == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
